[hdl/dstd_pkg.sv]
// Shared types and constants for the dual-side turn detector.
// Used by dstd_side and dual_side_turn_detector_unit; depends on nothing.
package dstd_pkg;

    // Operation codes carried in the low bits of an input item
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_SOFTRST = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] CFG_COUNT_THRESHOLD = 8'd0;
    localparam logic [7:0] CFG_STABLE_TIME     = 8'd1;
    localparam logic [7:0] CFG_DETECT_TIMEOUT  = 8'd2;
    localparam logic [7:0] CFG_LOCKOUT_TIME    = 8'd3;

    // Configuration reset values
    localparam logic [1:0]  RST_COUNT_THRESHOLD = 2'd2;
    localparam logic [15:0] RST_STABLE_TIME     = 16'd2;
    localparam logic [15:0] RST_DETECT_TIMEOUT  = 16'd100;
    localparam logic [15:0] RST_LOCKOUT_TIME    = 16'd800;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_DETECTING = 2'd1,
        PH_CONFIRMED = 2'd2,
        PH_INHIBITED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] detect_begin;
        logic [31:0] lockout_begin;
    } side_state_t;

    typedef struct packed {
        logic [1:0]  count_threshold;
        logic [15:0] stable_time;
        logic [15:0] detect_timeout;
        logic [15:0] lockout_time;
    } side_cfg_t;

endpackage

[hdl/dstd_side.sv]
// Next-state logic for one side of the turn detector: sensor count,
// phase transitions and pending-turn latch. Depends on dstd_pkg.
module dstd_side (
    input  dstd_pkg::side_cfg_t   cfg,
    input  dstd_pkg::side_state_t state_cur,
    input  logic [31:0]           time_now,
    input  logic [2:0]            sensor_bits,
    input  dstd_pkg::dir_t        side_dir,
    input  dstd_pkg::dir_t        pending_cur,
    output dstd_pkg::side_state_t state_next,
    output dstd_pkg::dir_t        pending_next
);
    import dstd_pkg::*;

    logic [1:0]  ones;
    logic        above;
    logic [31:0] detect_elapsed;
    logic [31:0] lockout_elapsed;

    // Count active sensors and compare with the threshold
    assign ones  = {1'b0, sensor_bits[0]} + {1'b0, sensor_bits[1]} + {1'b0, sensor_bits[2]};
    assign above = (ones >= cfg.count_threshold);

    // Wrapping time differences
    assign detect_elapsed  = time_now - state_cur.detect_begin;
    assign lockout_elapsed = time_now - state_cur.lockout_begin;

    // Advance the phase machine
    always_comb begin
        state_next   = state_cur;
        pending_next = pending_cur;
        case (state_cur.phase)
            PH_IDLE: begin
                if (above) begin
                    state_next.phase        = PH_DETECTING;
                    state_next.detect_begin = time_now;
                end
            end
            PH_DETECTING: begin
                if (!above) begin
                    state_next.phase = PH_IDLE;
                end else if (detect_elapsed >= {16'd0, cfg.stable_time}) begin
                    state_next.phase         = PH_CONFIRMED;
                    state_next.lockout_begin = time_now;
                    if (pending_cur == DIR_NONE) begin
                        pending_next = side_dir;
                    end
                end else if (detect_elapsed >= {16'd0, cfg.detect_timeout}) begin
                    state_next.phase = PH_IDLE;
                end
            end
            PH_CONFIRMED: begin
                state_next.phase         = PH_INHIBITED;
                state_next.lockout_begin = time_now;
            end
            default: begin
                if (lockout_elapsed >= {16'd0, cfg.lockout_time}) begin
                    state_next.phase = PH_IDLE;
                end
            end
        endcase
    end

endmodule

[hdl/dual_side_turn_detector_unit.sv]
// Dual-side turn detector: input item register, per-side phase logic and
// result register. Depends on dstd_pkg and dstd_side.
// An accepted item passes through the input register, then the result register,
// before its result can be taken.
// Throughput: one item per cycle while the result side is not stalled, set by the
// single pass through the two side machines between the registers.
// Reset (aresetn low, synchronous): phases idle, timestamps zero, no pending
// turn, registers at their reset values, both pipeline stages empty.
module dual_side_turn_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[1:0], time_now[33:2], left_bits[36:34],
                                   // right_bits[39:37]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // direction[1:0], left_phase[3:2], right_phase[5:4],
                                   // zero fill [7:6]
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dstd_pkg::*;

    // Configuration registers
    side_cfg_t   cfg_reg;

    // Input item stage
    logic        in_valid_reg;
    logic [39:0] in_data_reg;

    // Detector state
    side_state_t left_reg,  left_next;
    side_state_t right_reg, right_next;
    dir_t        pending_reg, pending_next;

    // Result stage
    logic        out_valid_reg;
    logic [7:0]  out_data_reg, out_data_next;

    logic        advance;
    logic [1:0]  opcode;
    logic [31:0] time_now;
    side_state_t left_upd, right_upd;
    dir_t        pending_after_left, pending_after_right;
    dir_t        dir_out;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count_threshold <= RST_COUNT_THRESHOLD;
            cfg_reg.stable_time     <= RST_STABLE_TIME;
            cfg_reg.detect_timeout  <= RST_DETECT_TIMEOUT;
            cfg_reg.lockout_time    <= RST_LOCKOUT_TIME;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COUNT_THRESHOLD: cfg_reg.count_threshold <= cfg_data[1:0];
                CFG_STABLE_TIME:     cfg_reg.stable_time     <= cfg_data;
                CFG_DETECT_TIMEOUT:  cfg_reg.detect_timeout  <= cfg_data;
                CFG_LOCKOUT_TIME:    cfg_reg.lockout_time    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Move the input item on when the result stage is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Hold or load the input item stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    assign opcode   = in_data_reg[1:0];
    assign time_now = in_data_reg[33:2];

    // Step the left side first, then the right with the updated pending turn
    dstd_side u_left (
        .cfg          (cfg_reg),
        .state_cur    (left_reg),
        .time_now     (time_now),
        .sensor_bits  (in_data_reg[36:34]),
        .side_dir     (DIR_LEFT),
        .pending_cur  (pending_reg),
        .state_next   (left_upd),
        .pending_next (pending_after_left)
    );

    dstd_side u_right (
        .cfg          (cfg_reg),
        .state_cur    (right_reg),
        .time_now     (time_now),
        .sensor_bits  (in_data_reg[39:37]),
        .side_dir     (DIR_RIGHT),
        .pending_cur  (pending_after_left),
        .state_next   (right_upd),
        .pending_next (pending_after_right)
    );

    // Apply the operation and form the result
    always_comb begin
        left_next    = left_reg;
        right_next   = right_reg;
        pending_next = pending_reg;
        dir_out      = pending_reg;
        case (opcode)
            OP_UPDATE: begin
                left_next    = left_upd;
                right_next   = right_upd;
                pending_next = pending_after_right;
                dir_out      = pending_after_right;
            end
            OP_CONSUME: begin
                pending_next = DIR_NONE;
                dir_out      = pending_reg;
            end
            OP_SOFTRST: begin
                left_next.phase  = PH_IDLE;
                right_next.phase = PH_IDLE;
                pending_next     = DIR_NONE;
                dir_out          = DIR_NONE;
            end
            default: ;
        endcase
        out_data_next = {2'b00, right_next.phase, left_next.phase, dir_out};
    end

    // Commit detector state as the item moves into the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '{phase: PH_IDLE, detect_begin: 32'd0, lockout_begin: 32'd0};
            right_reg   <= '{phase: PH_IDLE, detect_begin: 32'd0, lockout_begin: 32'd0};
            pending_reg <= DIR_NONE;
        end else if (in_valid_reg && advance) begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            pending_reg <= pending_next;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A pending turn is only ever cleared, never replaced by another
    a_pending_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != DIR_NONE |=>
            (pending_reg == $past(pending_reg) || pending_reg == DIR_NONE))
        else $error("pending turn overwritten");

    // An item held in the input stage is not dropped while the output stalls
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost during stall");

    // A side cannot jump from idle straight to confirmed
    a_left_no_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg.phase == PH_IDLE |=> left_reg.phase != PH_CONFIRMED)
        else $error("left side skipped detecting");

    a_right_no_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        right_reg.phase == PH_IDLE |=> right_reg.phase != PH_CONFIRMED)
        else $error("right side skipped detecting");

endmodule
